@@ hw/rtl/hcbd_pkg.sv @@
// Shared types and constants for the chunked HTTP body decoder.
package hcbd_pkg;

  // Default width of the chunk size counter.
  localparam int SIZE_BITS_DEF = 32;

  // Result kind codes.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  // Special bytes of the size line.
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // One result item from the decoder core.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic [1:0] kind;
  } res_t;

endpackage

@@ hw/rtl/hcbd_in_stage.sv @@
// Input register stage that holds one accepted byte for the decoder core.
module hcbd_in_stage
  import hcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       adv,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // The stage takes a new item when it is empty or is handing its item on.
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_byte  = s1_byte_r;

endmodule

@@ hw/rtl/hcbd_core.sv @@
// Chunk parsing state machine: size line, payload, trailer, end and error.
module hcbd_core
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic [7:0] byte_in,
  output res_t       res
);

  localparam logic [2:0] PH_SIZE = 3'd0;
  localparam logic [2:0] PH_LF   = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_TR1  = 3'd3;
  localparam logic [2:0] PH_TR2  = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_ERR  = 3'd6;

  logic [2:0]           phase_r, phase_nxt;
  logic [SIZE_BITS-1:0] count_r, count_nxt;
  logic                 seen_r, seen_nxt;
  logic                 is_hex;
  logic [3:0]           hex_val;
  logic [SIZE_BITS-1:0] count_dec;

  // Hex digit decode, either case.
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
      hex_val = 4'(byte_in - 8'h30);
    end else if (byte_in >= 8'h61 && byte_in <= 8'h66) begin
      hex_val = 4'(byte_in - 8'h57);
    end else if (byte_in >= 8'h41 && byte_in <= 8'h46) begin
      hex_val = 4'(byte_in - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign count_dec = count_r - SIZE_BITS'(1);

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    res.vld   = 1'b0;
    res.data  = 8'd0;
    res.kind  = KIND_PAYLOAD;
    case (phase_r)
      PH_SIZE: begin
        if (is_hex) begin
          if (count_r[SIZE_BITS-1 -: 4] != 4'd0) begin
            phase_nxt = PH_ERR;
            res.vld   = 1'b1;
            res.kind  = KIND_ERROR;
          end else begin
            count_nxt = {count_r[SIZE_BITS-5:0], hex_val};
            seen_nxt  = 1'b1;
          end
        end else if (byte_in == CHAR_CR && seen_r) begin
          phase_nxt = PH_LF;
        end else begin
          phase_nxt = PH_ERR;
          res.vld   = 1'b1;
          res.kind  = KIND_ERROR;
        end
      end
      PH_LF: begin
        if (byte_in != CHAR_LF) begin
          phase_nxt = PH_ERR;
          res.vld   = 1'b1;
          res.kind  = KIND_ERROR;
        end else if (count_r == '0) begin
          phase_nxt = PH_DONE;
          res.vld   = 1'b1;
          res.kind  = KIND_END;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        count_nxt = count_dec;
        if (count_dec == '0) begin
          phase_nxt = PH_TR1;
        end
        res.vld  = 1'b1;
        res.data = byte_in;
        res.kind = KIND_PAYLOAD;
      end
      PH_TR1: begin
        phase_nxt = PH_TR2;
      end
      PH_TR2: begin
        phase_nxt = PH_SIZE;
        count_nxt = '0;
        seen_nxt  = 1'b0;
      end
      default: begin
        // Done and error phases swallow every byte.
      end
    endcase
  end

  // State advances only when the input register hands on its byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIZE;
      count_r <= '0;
      seen_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

@@ hw/rtl/hcbd_out_stage.sv @@
// Output register that holds one result item until the receiver takes it.
module hcbd_out_stage
  import hcbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  res_t       res,
  output logic       out_free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic [1:0] out_tuser
);

  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic [1:0] out_kind_r;

  // The register can load when empty or when its item leaves this cycle.
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= fire && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && fire && res.vld) begin
      out_data_r <= res.data;
      out_kind_r <= res.kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

endmodule

@@ hw/rtl/http_chunked_body_decoder.sv @@
// Top level of the chunked HTTP body decoder.
//
// Usage: raw body bytes enter on the in_ stream, one byte per item in
// in_tdata. Decoded items leave on the out_ stream: out_tdata carries the
// payload byte (zero for other kinds) and out_tuser the kind, 0 for a
// payload byte, 1 for end of body and 2 for a malformed stream.
// Each input byte gives zero or one result item. The core computes it from
// the byte held in the input register; it is then loaded into the output
// register, and the output register holds it until the receiver takes it.
// The block accepts one byte every cycle while the receiver keeps up; the
// input register and the output register each hold one item, so up to two
// items are buffered.
// When the receiver stalls, the output register holds its item and the
// input register fills; in_tready then falls until the output moves.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the start of a size line. After an end or error result the
// block keeps accepting bytes but emits nothing until reset.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser   // [1:0] out_kind
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       out_free;
  logic       adv;
  res_t       res;

  // The held byte moves on whenever the output register can take a result.
  assign adv = s1_valid && out_free;

  hcbd_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .adv       (adv),
    .s1_valid  (s1_valid),
    .s1_byte   (s1_byte)
  );

  hcbd_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .byte_in (s1_byte),
    .res     (res)
  );

  hcbd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (adv),
    .res        (res),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef ASSERT_OFF
  // The kind code never takes the unused value.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == KIND_PAYLOAD || out_tuser == KIND_END ||
                    out_tuser == KIND_ERROR))
    else $error("unused result kind");

  // Non-payload kinds carry a zero byte.
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != KIND_PAYLOAD) |-> (out_tdata == 8'd0))
    else $error("non-payload result with nonzero byte");

  // An error result is the last item the block ever emits.
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tuser == KIND_ERROR) |=> !out_tvalid)
    else $error("result after error");

  // With the output register empty the input side is never blocked.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");
`endif

endmodule
